@@ sv/heating_pump_supervisor_macros.svh @@
// Assertion macros shared by the heating pump supervisor RTL.
`ifndef HEATING_PUMP_SUPERVISOR_MACROS_SVH
`define HEATING_PUMP_SUPERVISOR_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled while arst_n is low.
`define HPS_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("hps assertion failed");

// Next-cycle implication, clocked on clk, disabled while arst_n is low.
`define HPS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("hps assertion failed");

`endif

@@ sv/hps_pkg.sv @@
// Types and constants of the heating pump supervisor.
package hps_pkg;

	typedef enum logic [1:0] {
		KIND_READING = 2'd0,
		KIND_MANUAL  = 2'd1,
		KIND_TICK    = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RSN_COLD     = 3'd0,
		RSN_HOT      = 3'd1,
		RSN_MAN_ON   = 3'd2,
		RSN_MAN_OFF  = 3'd3,
		RSN_MAINT    = 3'd4,
		RSN_SENSOR   = 3'd5,
		RSN_OVERHEAT = 3'd6
	} reason_t;

	// manual override modes; the spare code counts as none
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRIT_TEMP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TEMP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_TEMP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAINT_INT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAINT_LEN  = 3'd5;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [7:0]  RST_FAIL_LIMIT = 8'd3;
	localparam logic [15:0] RST_CRIT_TEMP  = 16'd850;
	localparam logic [15:0] RST_START_TEMP = 16'd300;
	localparam logic [15:0] RST_STOP_TEMP  = 16'd250;
	localparam logic [31:0] RST_MAINT_INT  = 32'd604800;
	localparam logic [31:0] RST_MAINT_LEN  = 32'd60;

	localparam logic [16:0] OVERHEAT_HYST = 17'd20;
	localparam logic [7:0]  FAIL_MAX      = 8'hFF;

	// temperatures are raw two's complement bits
	typedef struct packed {
		logic [7:0]  fail_limit;
		logic [15:0] crit_temp;
		logic [15:0] start_temp;
		logic [15:0] stop_temp;
		logic [31:0] maint_int;
		logic [31:0] maint_len;
	} cfg_t;

	// packed so that accepted lands in bit 0
	typedef struct packed {
		reason_t    reason;
		logic       pump_on;
		reason_t    reason_was;
		logic       switched;
		logic       maint_started;
		logic       stop_dropped;
		logic       ovr_timeout;
		logic       ovht_clear;
		logic       ovht_set;
		logic       sensor_back;
		logic       sensor_failed_event;
		logic       accepted;
	} res_t;

endpackage

@@ sv/hps_core.sv @@
// Supervisor state and the per-item update logic.
module hps_core #(
	parameter int unsigned TIME_WIDTH = 32,
	parameter int unsigned TEMP_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  hps_pkg::kind_t        kind,
	input  logic [TIME_WIDTH-1:0] now_time,
	input  logic                  reading_valid,
	input  logic [TEMP_WIDTH-1:0] temperature,
	input  logic [1:0]            manual_mode,
	input  logic [31:0]           manual_length,
	input  hps_pkg::cfg_t         cfg,
	output hps_pkg::res_t         res
);
	import hps_pkg::*;
	`include "heating_pump_supervisor_macros.svh"

	localparam int unsigned CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
	localparam int unsigned SW = CW + 1;

	logic [7:0]            fail_count_q, fail_count_d;
	logic                  sensor_bad_q, sensor_bad_d;
	logic                  have_reading_q, have_reading_d;
	logic [TEMP_WIDTH-1:0] last_temp_q, last_temp_d;
	logic                  overheat_q, overheat_d;
	logic                  hot_q, hot_d;
	logic [1:0]            ovr_mode_q, ovr_mode_d;
	logic [TIME_WIDTH-1:0] ovr_until_q, ovr_until_d;
	logic                  maint_active_q, maint_active_d;
	logic [TIME_WIDTH-1:0] maint_until_q, maint_until_d;
	logic                  pump_q, pump_d;
	logic [TIME_WIDTH-1:0] last_on_q, last_on_d;
	reason_t               reason_q, reason_d;

	function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
		input logic [31:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		return (|s[SW-1:TIME_WIDTH]) ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
	endfunction

	logic signed [16:0] temp_x, last_x, crit_x, crit_lo_x, start_x, stop_x;
	logic [1:0]         mode_in;
	logic [TIME_WIDTH-1:0] off_span;
	logic [CW-1:0]      off_span_x, maint_int_x;
	logic               maint_due;
	logic               on_sel;
	reason_t            why_sel;

	always_comb begin
		temp_x    = signed'({{(17-TEMP_WIDTH){temperature[TEMP_WIDTH-1]}}, temperature});
		last_x    = signed'({{(17-TEMP_WIDTH){last_temp_q[TEMP_WIDTH-1]}}, last_temp_q});
		crit_x    = signed'({cfg.crit_temp[15], cfg.crit_temp});
		crit_lo_x = crit_x - signed'(OVERHEAT_HYST);
		start_x   = signed'({cfg.start_temp[15], cfg.start_temp});
		stop_x    = signed'({cfg.stop_temp[15], cfg.stop_temp});
		mode_in   = (manual_mode == MODE_START || manual_mode == MODE_STOP) ? manual_mode
			: MODE_NONE;
	end

	always_comb begin
		fail_count_d   = fail_count_q;
		sensor_bad_d   = sensor_bad_q;
		have_reading_d = have_reading_q;
		last_temp_d    = last_temp_q;
		overheat_d     = overheat_q;
		hot_d          = hot_q;
		ovr_mode_d     = ovr_mode_q;
		ovr_until_d    = ovr_until_q;
		maint_active_d = maint_active_q;
		maint_until_d  = maint_until_q;
		pump_d         = pump_q;
		last_on_d      = last_on_q;
		reason_d       = reason_q;
		res            = '0;
		res.accepted   = 1'b1;
		off_span       = '0;
		off_span_x     = '0;
		maint_int_x    = CW'(cfg.maint_int);
		maint_due      = 1'b0;
		on_sel         = 1'b0;
		why_sel        = RSN_COLD;

		unique case (kind)
			KIND_READING: begin
				if (!reading_valid) begin
					if (fail_count_q != FAIL_MAX) begin
						fail_count_d = fail_count_q + 8'd1;
					end
					if (!sensor_bad_q && fail_count_d >= cfg.fail_limit) begin
						sensor_bad_d = 1'b1;
						res.sensor_failed_event = 1'b1;
					end
				end else begin
					res.sensor_back = sensor_bad_q;
					sensor_bad_d   = 1'b0;
					fail_count_d   = '0;
					have_reading_d = 1'b1;
					last_temp_d    = temperature;
					if (!overheat_q && temp_x >= crit_x) begin
						overheat_d = 1'b1;
						res.ovht_set = 1'b1;
					end else if (overheat_q && temp_x < crit_lo_x) begin
						overheat_d = 1'b0;
						res.ovht_clear = 1'b1;
					end
					if (temp_x > start_x) begin
						hot_d = 1'b1;
					end else if (temp_x < stop_x) begin
						hot_d = 1'b0;
					end
				end
			end
			KIND_MANUAL: begin
				if (mode_in == MODE_STOP && overheat_q) begin
					res.accepted = 1'b0;
				end else begin
					ovr_mode_d  = mode_in;
					ovr_until_d = (mode_in == MODE_NONE) ? '0 : sat_add(now_time, manual_length);
				end
			end
			KIND_TICK: begin
				if (ovr_mode_q != MODE_NONE && now_time >= ovr_until_q) begin
					ovr_mode_d = MODE_NONE;
					res.ovr_timeout = 1'b1;
				end
				if (ovr_mode_d == MODE_STOP && overheat_q) begin
					ovr_mode_d = MODE_NONE;
					res.stop_dropped = 1'b1;
				end
				if (pump_q) begin
					last_on_d = now_time;
				end
				if (maint_active_q && now_time >= maint_until_q) begin
					maint_active_d = 1'b0;
				end
				off_span   = now_time - last_on_d;
				off_span_x = CW'(off_span);
				maint_due  = !maint_active_d && !pump_q && ovr_mode_d == MODE_NONE
					&& !sensor_bad_q && have_reading_q && last_x < stop_x
					&& now_time >= last_on_d && off_span_x >= maint_int_x;
				if (maint_due) begin
					maint_active_d = 1'b1;
					maint_until_d  = sat_add(now_time, cfg.maint_len);
					res.maint_started = 1'b1;
				end
				// fixed priority
				if (overheat_q) begin
					on_sel = 1'b1; why_sel = RSN_OVERHEAT;
				end else if (ovr_mode_d == MODE_START) begin
					on_sel = 1'b1; why_sel = RSN_MAN_ON;
				end else if (ovr_mode_d == MODE_STOP) begin
					on_sel = 1'b0; why_sel = RSN_MAN_OFF;
				end else if (sensor_bad_q) begin
					on_sel = 1'b1; why_sel = RSN_SENSOR;
				end else if (hot_q) begin
					on_sel = 1'b1; why_sel = RSN_HOT;
				end else if (maint_active_d) begin
					on_sel = 1'b1; why_sel = RSN_MAINT;
				end else begin
					on_sel = 1'b0; why_sel = RSN_COLD;
				end
				res.switched = (on_sel != pump_q);
				pump_d       = on_sel;
				if (on_sel) begin
					last_on_d = now_time;
				end
				reason_d = why_sel;
			end
			KIND_RESTART: begin
				fail_count_d   = '0;
				sensor_bad_d   = 1'b0;
				have_reading_d = 1'b0;
				last_temp_d    = '0;
				overheat_d     = 1'b0;
				hot_d          = 1'b0;
				ovr_mode_d     = MODE_NONE;
				ovr_until_d    = '0;
				maint_active_d = 1'b0;
				maint_until_d  = '0;
				pump_d         = 1'b0;
				last_on_d      = now_time;
				reason_d       = RSN_COLD;
			end
			default: begin
			end
		endcase

		// reason_was is the old reason on a tick, the new one otherwise
		res.reason_was = (kind == KIND_TICK) ? reason_q : reason_d;
		res.pump_on    = pump_d;
		res.reason     = reason_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count_q   <= '0;
			sensor_bad_q   <= 1'b0;
			have_reading_q <= 1'b0;
			last_temp_q    <= '0;
			overheat_q     <= 1'b0;
			hot_q          <= 1'b0;
			ovr_mode_q     <= MODE_NONE;
			ovr_until_q    <= '0;
			maint_active_q <= 1'b0;
			maint_until_q  <= '0;
			pump_q         <= 1'b0;
			last_on_q      <= '0;
			reason_q       <= RSN_COLD;
		end else if (en) begin
			fail_count_q   <= fail_count_d;
			sensor_bad_q   <= sensor_bad_d;
			have_reading_q <= have_reading_d;
			last_temp_q    <= last_temp_d;
			overheat_q     <= overheat_d;
			hot_q          <= hot_d;
			ovr_mode_q     <= ovr_mode_d;
			ovr_until_q    <= ovr_until_d;
			maint_active_q <= maint_active_d;
			maint_until_q  <= maint_until_d;
			pump_q         <= pump_d;
			last_on_q      <= last_on_d;
			reason_q       <= reason_d;
		end
	end

	// sensor can only be failed after at least one bad read
	`HPS_ASSERT_IMPL(a_bad_has_count, sensor_bad_q, fail_count_q != 8'd0)
	// pump state and stored reason agree
	`HPS_ASSERT_IMPL(a_pump_reason, 1'b1,
		pump_q == (reason_q == RSN_HOT || reason_q == RSN_MAN_ON || reason_q == RSN_MAINT
		|| reason_q == RSN_SENSOR || reason_q == RSN_OVERHEAT))
	// a manual stop never survives into a state with overheat after a tick
	`HPS_ASSERT_NEXT(a_stop_cancel, en && kind == KIND_TICK,
		!(ovr_mode_q == MODE_STOP && overheat_q))

endmodule

@@ sv/heating_pump_supervisor.sv @@
// Top level of the heating pump supervisor: stream ports, config, pipeline registers.
// Heating pump supervisor.
// Input stream s_*: one timestamped item per transfer; s_tuser carries the item
// kind (reading, manual command, decision tick, restart), s_tdata the fields.
// Output stream m_*: exactly one result per input item, in order, with event
// flags, accepted, reason_was, pump_on and reason.
// Config: cfg_we with cfg_index/cfg_wdata writes one register per clock; write
// only while the block is idle.
// Pipeline: an accepted item sits in the input register while the state
// update runs; its result is captured in the output register, which drives
// m_tvalid, and the output transfer is made from there.
// Throughput: one item per cycle while m_tready does not hold the output;
// the state registers update once per item, so back-to-back items never wait on each other.
// Stall: when m_tready is low the result holds in the output register, the
// item behind it holds in the input register, and s_tready drops only when
// both are full.
// Reset (arst_n low): all supervisor state clears, config registers return to
// their default values, both streams go empty.
module heating_pump_supervisor #(
	parameter int unsigned TIME_WIDTH = 32,
	parameter int unsigned TEMP_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// kind[1:0]
	input  logic [1:0] s_tuser,
	// now_time, reading_valid, temperature, manual_mode, manual_length, zero fill
	input  logic [(((TIME_WIDTH+TEMP_WIDTH+35)+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// accepted, sensor_failed_event, sensor_back, ovht_set,
	// ovht_clear, ovr_timeout, stop_dropped, maint_started,
	// switched, reason_was[2:0], pump_on, reason[2:0]
	output logic [15:0] m_tdata,
	input  logic cfg_we,
	input  logic [hps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import hps_pkg::*;
	`include "heating_pump_supervisor_macros.svh"

	localparam int unsigned OFF_VALID = TIME_WIDTH;
	localparam int unsigned OFF_TEMP  = OFF_VALID + 1;
	localparam int unsigned OFF_MODE  = OFF_TEMP + TEMP_WIDTH;
	localparam int unsigned OFF_LEN   = OFF_MODE + 2;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fail_limit <= RST_FAIL_LIMIT;
			cfg_q.crit_temp  <= RST_CRIT_TEMP;
			cfg_q.start_temp <= RST_START_TEMP;
			cfg_q.stop_temp  <= RST_STOP_TEMP;
			cfg_q.maint_int  <= RST_MAINT_INT;
			cfg_q.maint_len  <= RST_MAINT_LEN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FAIL_LIMIT: cfg_q.fail_limit <= cfg_wdata[7:0];
				CFG_CRIT_TEMP:  cfg_q.crit_temp  <= cfg_wdata[15:0];
				CFG_START_TEMP: cfg_q.start_temp <= cfg_wdata[15:0];
				CFG_STOP_TEMP:  cfg_q.stop_temp  <= cfg_wdata[15:0];
				CFG_MAINT_INT:  cfg_q.maint_int  <= cfg_wdata;
				CFG_MAINT_LEN:  cfg_q.maint_len  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// input register
	logic                  valid_s1;
	kind_t                 kind_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  rvalid_s1;
	logic [TEMP_WIDTH-1:0] temp_s1;
	logic [1:0]            mode_s1;
	logic [31:0]           len_s1;

	res_t res_c, res_q;
	logic advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1   <= kind_t'(s_tuser);
			now_s1    <= s_tdata[TIME_WIDTH-1:0];
			rvalid_s1 <= s_tdata[OFF_VALID];
			temp_s1   <= s_tdata[OFF_TEMP +: TEMP_WIDTH];
			mode_s1   <= s_tdata[OFF_MODE +: 2];
			len_s1    <= s_tdata[OFF_LEN +: 32];
		end
	end

	hps_core #(
		.TIME_WIDTH(TIME_WIDTH),
		.TEMP_WIDTH(TEMP_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.kind         (kind_s1),
		.now_time     (now_s1),
		.reading_valid(rvalid_s1),
		.temperature  (temp_s1),
		.manual_mode  (mode_s1),
		.manual_length(len_s1),
		.cfg          (cfg_q),
		.res          (res_c)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign m_tdata = res_q;

	`HPS_ASSERT_NEXT(a_adv_gives_out, advance, m_tvalid)
	`HPS_ASSERT_IMPL(a_ready_when_out_empty, !m_tvalid, s_tready)
	`HPS_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1)

endmodule

@@ sim/heating_pump_supervisor_test.sv @@
// Self-checking testbench for the heating pump supervisor: stream driver, monitor, predictor.
module heating_pump_supervisor_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hps_pkg::*;

	localparam int unsigned DATA_W = 88;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct {
		kind_t              kind;
		logic [31:0]        now;
		logic               valid;
		logic signed [15:0] temp;
		logic [1:0]         mode;
		logic [31:0]        len;
	} pump_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [1:0] s_tuser = '0;
	logic [DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	heating_pump_supervisor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the supervisor: configuration and state
	cfg_t        cfg;
	logic [7:0]  bad_reads;
	logic        sensor_bad, have_reading, overheat, hot, maint_on, pump;
	int          last_temp;
	logic [1:0]  ovr_mode;
	logic [31:0] ovr_until, maint_until, last_on;
	reason_t     cur_reason;

	pump_item_t  pend_q[$];
	res_t        outcome_q[$];
	pump_item_t  cur_item;
	int          issued = 0;
	int          retired = 0;
	int          err_count = 0;
	int          cycles = 0;
	int          phases = 0;
	int          kind_seen[4] = '{0, 0, 0, 0};
	int          switch_count = 0;
	int          maint_count = 0;
	logic [31:0] clock_s = '0;

	function automatic logic [31:0] sat_time(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic void clear_supervisor();
		bad_reads = '0;
		sensor_bad = 1'b0;
		have_reading = 1'b0;
		last_temp = 0;
		overheat = 1'b0;
		hot = 1'b0;
		ovr_mode = MODE_NONE;
		ovr_until = '0;
		maint_on = 1'b0;
		maint_until = '0;
		pump = 1'b0;
		last_on = '0;
		cur_reason = RSN_COLD;
	endfunction

	function automatic res_t step_supervisor(input pump_item_t it);
		res_t       r;
		logic [1:0] mode;
		int         t, crit, start_t, stop_t;
		logic       on;
		reason_t    why;
		r = '0;
		r.accepted = 1'b1;
		mode = (it.mode == MODE_SPARE) ? MODE_NONE : it.mode;
		t = it.temp;
		crit = $signed(cfg.crit_temp);
		start_t = $signed(cfg.start_temp);
		stop_t = $signed(cfg.stop_temp);
		case (it.kind)
			KIND_READING: begin
				if (!it.valid) begin
					if (bad_reads < FAIL_MAX) bad_reads++;
					if (!sensor_bad && bad_reads >= cfg.fail_limit) begin
						sensor_bad = 1'b1;
						r.sensor_failed_event = 1'b1;
					end
				end else begin
					r.sensor_back = sensor_bad;
					sensor_bad = 1'b0;
					bad_reads = '0;
					have_reading = 1'b1;
					last_temp = t;
					if (!overheat && t >= crit) begin
						overheat = 1'b1;
						r.ovht_set = 1'b1;
					end else if (overheat && t < crit - 20) begin
						overheat = 1'b0;
						r.ovht_clear = 1'b1;
					end
					if (t > start_t) hot = 1'b1;
					else if (t < stop_t) hot = 1'b0;
				end
			end
			KIND_MANUAL: begin
				if (mode == MODE_STOP && overheat) begin
					r.accepted = 1'b0;
				end else begin
					ovr_mode = mode;
					ovr_until = (mode == MODE_NONE) ? '0 : sat_time(it.now, it.len);
				end
			end
			KIND_TICK: begin
				if (ovr_mode != MODE_NONE && it.now >= ovr_until) begin
					ovr_mode = MODE_NONE;
					r.ovr_timeout = 1'b1;
				end
				if (ovr_mode == MODE_STOP && overheat) begin
					ovr_mode = MODE_NONE;
					r.stop_dropped = 1'b1;
				end
				if (pump) last_on = it.now;
				if (maint_on && it.now >= maint_until) maint_on = 1'b0;
				if (!maint_on && !pump && ovr_mode == MODE_NONE && !sensor_bad && have_reading
						&& last_temp < stop_t && it.now >= last_on
						&& it.now - last_on >= cfg.maint_int) begin
					maint_on = 1'b1;
					maint_until = sat_time(it.now, cfg.maint_len);
					r.maint_started = 1'b1;
				end
				if (overheat) begin
					on = 1'b1; why = RSN_OVERHEAT;
				end else if (ovr_mode == MODE_START) begin
					on = 1'b1; why = RSN_MAN_ON;
				end else if (ovr_mode == MODE_STOP) begin
					on = 1'b0; why = RSN_MAN_OFF;
				end else if (sensor_bad) begin
					on = 1'b1; why = RSN_SENSOR;
				end else if (hot) begin
					on = 1'b1; why = RSN_HOT;
				end else if (maint_on) begin
					on = 1'b1; why = RSN_MAINT;
				end else begin
					on = 1'b0; why = RSN_COLD;
				end
				if (on != pump) begin
					pump = on;
					r.switched = 1'b1;
				end
				if (on) last_on = it.now;
			end
			default: begin
				clear_supervisor();
				last_on = it.now;
			end
		endcase
		r.reason_was = cur_reason;
		if (it.kind == KIND_TICK) cur_reason = why;
		r.pump_on = pump;
		r.reason = cur_reason;
		return r;
	endfunction

	function automatic logic roll_idle();
		// one long window in each repeating period of the cycle count runs with no idling at all
		if ((cycles % 5000) < 1200) return 1'b0;
		return $urandom_range(99) < 20;
	endfunction

	// driver: one transfer per handshake, predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				outcome_q.push_back(step_supervisor(cur_item));
				kind_seen[cur_item.kind]++;
			end
			if (!s_tvalid || s_tready) begin
				if (pend_q.size() != 0 && !roll_idle()) begin
					cur_item = pend_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_item.kind;
					s_tdata <= {5'b0, cur_item.len, cur_item.mode, cur_item.temp,
						cur_item.valid, cur_item.now};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: result %0d %s expected %0d actual %0d", $realtime, retired, name,
				exp_v, act_v);
			err_count++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata);
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result expected none actual %h", $realtime, m_tdata);
					err_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("accepted", want.accepted, got.accepted);
					check_field("sensor_failed_event", want.sensor_failed_event,
						got.sensor_failed_event);
					check_field("sensor_back", want.sensor_back, got.sensor_back);
					check_field("ovht_set", want.ovht_set, got.ovht_set);
					check_field("ovht_clear", want.ovht_clear, got.ovht_clear);
					check_field("ovr_timeout", want.ovr_timeout, got.ovr_timeout);
					check_field("stop_dropped", want.stop_dropped, got.stop_dropped);
					check_field("maint_started", want.maint_started, got.maint_started);
					check_field("switched", want.switched, got.switched);
					check_field("reason_was", want.reason_was, got.reason_was);
					check_field("pump_on", want.pump_on, got.pump_on);
					check_field("reason", want.reason, got.reason);
					if (want.switched) switch_count++;
					if (want.maint_started) maint_count++;
				end
				retired++;
			end
			m_tready <= !roll_idle();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d results seen", cycles, retired, issued);
			$display("heating_pump_supervisor_test: FAIL");
			$finish;
		end
	end

	task automatic push_item(input kind_t kind, input logic [31:0] now, input int valid,
			input int temp, input logic [1:0] mode, input logic [31:0] len);
		pump_item_t it;
		it.kind = kind;
		it.now = now;
		it.valid = (valid != 0);
		it.temp = 16'(temp);
		it.mode = mode;
		it.len = len;
		pend_q.push_back(it);
		issued++;
	endtask

	// block is idle once every issued item has retired
	task automatic wait_idle();
		while (retired < issued) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_FAIL_LIMIT: cfg.fail_limit = value[7:0];
			CFG_CRIT_TEMP:  cfg.crit_temp = value[15:0];
			CFG_START_TEMP: cfg.start_temp = value[15:0];
			CFG_STOP_TEMP:  cfg.stop_temp = value[15:0];
			CFG_MAINT_INT:  cfg.maint_int = value;
			CFG_MAINT_LEN:  cfg.maint_len = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input int fail_lim, input int crit, input int start_t,
			input int stop_t, input logic [31:0] mint, input logic [31:0] mrun);
		wait_idle();
		write_reg(CFG_FAIL_LIMIT, 32'(fail_lim));
		write_reg(CFG_CRIT_TEMP, 32'(crit));
		write_reg(CFG_START_TEMP, 32'(start_t));
		write_reg(CFG_STOP_TEMP, 32'(stop_t));
		write_reg(CFG_MAINT_INT, mint);
		write_reg(CFG_MAINT_LEN, mrun);
		phases++;
	endtask

	function automatic int pick_temp();
		int base, v;
		case ($urandom_range(4))
			0: base = $signed(cfg.crit_temp);
			1: base = int'($signed(cfg.crit_temp)) - 20;
			2: base = $signed(cfg.start_temp);
			3: base = $signed(cfg.stop_temp);
			default: base = $signed(16'($urandom));
		endcase
		v = base + int'($urandom_range(12)) - 6;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	task automatic random_phase(input int n);
		int i, roll, t_roll;
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				// noise: every field random, time included
				push_item(kind_t'($urandom_range(3)), $urandom, int'($urandom_range(1)),
					$signed(16'($urandom)), 2'($urandom_range(3)), $urandom);
			end else begin
				t_roll = $urandom_range(99);
				if (t_roll < 3) clock_s = clock_s - $urandom_range(50);
				else if (t_roll < 8) clock_s = clock_s + cfg.maint_int + $urandom_range(3);
				else clock_s = clock_s + $urandom_range(15);
				if (roll < 50)
					push_item(KIND_READING, clock_s, int'($urandom_range(99) < 85), pick_temp(),
						2'($urandom_range(3)), $urandom);
				else if (roll < 83)
					push_item(KIND_TICK, clock_s, int'($urandom_range(1)),
						$signed(16'($urandom)), 2'($urandom_range(3)), $urandom);
				else if (roll < 97)
					push_item(KIND_MANUAL, clock_s, int'($urandom_range(1)),
						$signed(16'($urandom)), 2'($urandom_range(3)),
						($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(40)));
				else
					push_item(KIND_RESTART, clock_s, int'($urandom_range(1)),
						$signed(16'($urandom)), 2'($urandom_range(3)), $urandom);
			end
		end
	endtask

	initial begin
		int i;
		cfg.fail_limit = RST_FAIL_LIMIT;
		cfg.crit_temp = RST_CRIT_TEMP;
		cfg.start_temp = RST_START_TEMP;
		cfg.stop_temp = RST_STOP_TEMP;
		cfg.maint_int = RST_MAINT_INT;
		cfg.maint_len = RST_MAINT_LEN;
		clear_supervisor();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		phases = 1;

		// directed walk through the priorities at the reset settings
		push_item(KIND_RESTART, 100, 0, 0, MODE_NONE, 0);
		push_item(KIND_TICK, 100, 0, 0, MODE_NONE, 0);
		push_item(KIND_READING, 101, 1, 200, MODE_NONE, 0);
		push_item(KIND_READING, 102, 1, 310, MODE_NONE, 0);
		push_item(KIND_TICK, 103, 0, 0, MODE_NONE, 0);
		for (i = 0; i < 3; i++) push_item(KIND_READING, 104 + i, 0, 0, MODE_NONE, 0);
		push_item(KIND_TICK, 107, 0, 0, MODE_NONE, 0);
		push_item(KIND_READING, 108, 1, 850, MODE_NONE, 0);
		// stop refused while overheated
		push_item(KIND_MANUAL, 109, 0, 0, MODE_STOP, 30);
		push_item(KIND_TICK, 110, 0, 0, MODE_NONE, 0);
		push_item(KIND_READING, 111, 1, 830, MODE_NONE, 0);
		push_item(KIND_READING, 111, 1, 829, MODE_NONE, 0);
		push_item(KIND_MANUAL, 112, 0, 0, MODE_STOP, 30);
		push_item(KIND_TICK, 113, 0, 0, MODE_NONE, 0);
		// overheat during a manual stop cancels it
		push_item(KIND_READING, 114, 1, 32767, MODE_NONE, 0);
		push_item(KIND_TICK, 115, 0, 0, MODE_NONE, 0);
		push_item(KIND_READING, 116, 1, -32768, MODE_NONE, 0);
		push_item(KIND_MANUAL, 117, 0, 0, MODE_START, 5);
		push_item(KIND_TICK, 118, 0, 0, MODE_NONE, 0);
		push_item(KIND_TICK, 122, 0, 0, MODE_NONE, 0);
		push_item(KIND_MANUAL, 123, 0, 0, MODE_SPARE, 32'hFFFF_FFFF);
		// until-time saturates at the top of the time range
		push_item(KIND_MANUAL, 32'hFFFF_FFF0, 0, 0, MODE_START, 32'hFFFF_FFFF);
		push_item(KIND_TICK, 32'hFFFF_FFFF, 0, 0, MODE_NONE, 0);
		push_item(KIND_RESTART, 1000, 0, 0, MODE_NONE, 0);
		push_item(KIND_READING, 1000, 1, 100, MODE_NONE, 0);
		push_item(KIND_TICK, 1000 + 604800, 0, 0, MODE_NONE, 0);
		push_item(KIND_TICK, 1000 + 604860, 0, 0, MODE_NONE, 0);
		// clock running backwards
		push_item(KIND_TICK, 500, 0, 0, MODE_NONE, 0);

		set_config(0, 32767, -32768, 32767, 32'd0, 32'd0);
		random_phase(200);

		set_config(255, -32768, 32767, -32768, 32'd1, 32'd1);
		// long run of failed reads drives the counter into saturation
		for (i = 0; i < 260; i++) push_item(KIND_READING, clock_s, 0, 0, MODE_NONE, 0);
		random_phase(200);

		set_config(2, 400, 200, 150, 32'd40, 32'd15);
		random_phase(200);

		set_config(5, 850, 300, 250, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_phase(200);

		set_config($urandom_range(255), $signed(16'($urandom)), $signed(16'($urandom)),
			$signed(16'($urandom)), $urandom_range(200), $urandom);
		random_phase(200);

		wait_idle();
		if (outcome_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $realtime, outcome_q.size());
			err_count++;
		end
		$display("covered %0d readings, %0d manual commands, %0d ticks, %0d restarts",
			kind_seen[KIND_READING], kind_seen[KIND_MANUAL], kind_seen[KIND_TICK],
			kind_seen[KIND_RESTART]);
		$display("over %0d register settings: %0d pump switches, %0d maintenance runs, %0d errors",
			phases, switch_count, maint_count, err_count);
		if (err_count == 0) begin
			$display("heating_pump_supervisor_test: PASS");
		end else begin
			$display("heating_pump_supervisor_test: FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/hps_pkg.sv
sv/hps_core.sv
sv/heating_pump_supervisor.sv
sim/heating_pump_supervisor_test.sv
